// ===== src/lwwc_pkg.sv =====
// ----------------------------------------------------------------------------
// lwwc_pkg
// Shared types, opcodes and colour expansion for the LCD window write
// controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lwwc_pkg;

   // bus cycle kinds
   typedef enum logic [1:0] {
      ACT_COMMAND = 2'd0,
      ACT_BYTE    = 2'd1,
      ACT_WORD    = 2'd2
   } action_type;

   localparam logic [7:0] OP_SET_COLUMN     = 8'd42;
   localparam logic [7:0] OP_SET_PAGE       = 8'd43;
   localparam logic [7:0] OP_WRITE_START    = 8'd44;
   localparam logic [7:0] OP_WRITE_CONTINUE = 8'd60;

   localparam int unsigned PARAM_BYTES = 3;
   localparam logic [2:0]  PARAM_FULL  = 3'd4;
   localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] value;
   } req_word_type;

   typedef struct packed {
      logic        pixel_valid;
      logic [15:0] pixel_x;
      logic [15:0] pixel_y;
      logic [31:0] pixel_color;
      logic        data_ignored;
   } rsp_word_type;

   // RGB565 to ARGB8888, low colour bits left at zero
   function automatic logic [31:0] rgb565_to_argb(input logic [15:0] v);
      rgb565_to_argb = {ALPHA_OPAQUE, v[15:11], 3'b000, v[10:5], 2'b00, v[4:0], 3'b000};
   endfunction

endpackage

// ===== src/lwwc_if.sv =====
// ----------------------------------------------------------------------------
// lwwc_if
// Valid/ready channels for bus words in and pixel words out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lwwc_req_if;
   logic                     valid;
   logic                     ready;
   lwwc_pkg::req_word_type   payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface lwwc_rsp_if;
   logic                     valid;
   logic                     ready;
   lwwc_pkg::rsp_word_type   payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/lcd_window_write_controller.sv =====
// ----------------------------------------------------------------------------
// lcd_window_write_controller
// Every accepted bus word (command, data byte, data word or unused action)
// yields exactly one result word from the output register in the next cycle.
// Commands re-arm the parameter collector; column/page set commands take four
// bytes as a 16-bit start and end; data words under a memory write become
// ARGB8888 pixels at the running column/page pointer, which wraps at the
// window edge and stops past the last page. Throughput is one word per clock:
// the window state is updated in the accepting cycle, so the next word sees
// it at once, and req_chan.ready only drops while the output register holds
// a word that the sink is not taking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcd_window_write_controller (
   input  logic       clock,
   input  logic       reset,
   lwwc_req_if.sink   req_chan,
   lwwc_rsp_if.source rsp_chan
);

   logic [7:0]  current_command_ff, current_command_in;
   logic [7:0]  param_bytes_ff [lwwc_pkg::PARAM_BYTES];
   logic [7:0]  param_bytes_in [lwwc_pkg::PARAM_BYTES];
   logic [2:0]  param_count_ff, param_count_in;
   logic        accepting_ff, accepting_in;
   logic [15:0] column_start_ff, column_start_in;
   logic [15:0] column_end_ff, column_end_in;
   logic [15:0] page_start_ff, page_start_in;
   logic [15:0] page_end_ff, page_end_in;
   logic [15:0] next_column_ff, next_column_in;
   logic [15:0] next_page_ff, next_page_in;
   logic        rsp_valid_ff, rsp_valid_in;
   lwwc_pkg::rsp_word_type rsp_data_ff, rsp_data_in;

   logic        req_accept;
   logic        rsp_accept;
   logic [7:0]  low_byte;
   logic        is_write;
   logic        collect_col;
   logic        collect_page;
   logic [15:0] col_inc;
   logic [15:0] page_inc;
   logic [15:0] got_start;
   logic [15:0] got_end;
   logic        got_last;

   assign req_chan.ready   = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept       = req_chan.valid && req_chan.ready;
   assign rsp_accept       = rsp_valid_ff && rsp_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   assign low_byte = req_chan.payload.value[7:0];
   assign is_write = (current_command_ff == lwwc_pkg::OP_WRITE_START) ||
                     (current_command_ff == lwwc_pkg::OP_WRITE_CONTINUE);
   assign col_inc  = next_column_ff + 16'd1;
   assign page_inc = next_page_ff + 16'd1;

   // the fourth parameter byte completes a start/end pair
   assign got_start = {param_bytes_ff[0], param_bytes_ff[1]};
   assign got_end   = {param_bytes_ff[2], low_byte};
   assign got_last  = (param_count_ff >= 3'd3);

   always_comb begin
      current_command_in = current_command_ff;
      param_bytes_in     = param_bytes_ff;
      param_count_in     = param_count_ff;
      accepting_in       = accepting_ff;
      column_start_in    = column_start_ff;
      column_end_in      = column_end_ff;
      page_start_in      = page_start_ff;
      page_end_in        = page_end_ff;
      next_column_in     = next_column_ff;
      next_page_in       = next_page_ff;
      rsp_data_in        = '0;
      collect_col        = 1'b0;
      collect_page       = 1'b0;

      unique case (req_chan.payload.action) inside
         lwwc_pkg::ACT_COMMAND: begin
            accepting_in       = 1'b1;
            param_count_in     = 3'd0;
            current_command_in = low_byte;
            if (low_byte == lwwc_pkg::OP_WRITE_START) begin
               next_column_in = column_start_ff;
               next_page_in   = page_start_ff;
            end
         end
         lwwc_pkg::ACT_BYTE, lwwc_pkg::ACT_WORD: begin
            if (req_chan.payload.action == lwwc_pkg::ACT_WORD && is_write) begin
               if (accepting_ff) begin
                  rsp_data_in.pixel_valid = 1'b1;
                  rsp_data_in.pixel_x     = next_column_ff;
                  rsp_data_in.pixel_y     = next_page_ff;
                  rsp_data_in.pixel_color =
                     lwwc_pkg::rgb565_to_argb(req_chan.payload.value);
                  next_column_in = col_inc;
                  if (col_inc > column_end_ff) begin
                     next_column_in = column_start_ff;
                     next_page_in   = page_inc;
                     if (page_inc > page_end_ff) begin
                        accepting_in = 1'b0;
                     end
                  end
               end
            end else if (!is_write && current_command_ff == lwwc_pkg::OP_SET_COLUMN) begin
               collect_col = 1'b1;
            end else if (!is_write && current_command_ff == lwwc_pkg::OP_SET_PAGE) begin
               collect_page = 1'b1;
            end else begin
               rsp_data_in.data_ignored = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if ((collect_col || collect_page) && accepting_ff) begin
         if (!got_last) begin
            param_bytes_in[param_count_ff[1:0]] = low_byte;
            param_count_in = param_count_ff + 3'd1;
         end else begin
            param_count_in = lwwc_pkg::PARAM_FULL;
            accepting_in   = 1'b0;
            if (collect_col) begin
               column_start_in = got_start;
               column_end_in   = got_end;
            end else begin
               page_start_in = got_start;
               page_end_in   = got_end;
            end
         end
      end

      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_command_ff <= 8'd0;
         param_count_ff     <= 3'd0;
         accepting_ff       <= 1'b1;
         column_start_ff    <= 16'd0;
         column_end_ff      <= 16'd0;
         page_start_ff      <= 16'd0;
         page_end_ff        <= 16'd0;
         next_column_ff     <= 16'd0;
         next_page_ff       <= 16'd0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            current_command_ff <= current_command_in;
            param_count_ff     <= param_count_in;
            accepting_ff       <= accepting_in;
            column_start_ff    <= column_start_in;
            column_end_ff      <= column_end_in;
            page_start_ff      <= page_start_in;
            page_end_ff        <= page_end_in;
            next_column_ff     <= next_column_in;
            next_page_ff       <= next_page_in;
         end
      end
   end

   // parameter bytes and result word carry no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         param_bytes_ff <= param_bytes_in;
         rsp_data_ff    <= rsp_data_in;
      end
   end

   // ------------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------------
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.pixel_valid && rsp_data_ff.data_ignored))
      else $error("pixel and ignored flags both set");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.pixel_valid) |->
         (rsp_data_ff.pixel_x == 16'd0 && rsp_data_ff.pixel_y == 16'd0 &&
          rsp_data_ff.pixel_color == 32'd0))
      else $error("non-pixel word carries pixel fields");

   a_alpha: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.pixel_valid) |->
         rsp_data_ff.pixel_color[31:24] == lwwc_pkg::ALPHA_OPAQUE)
      else $error("pixel not opaque");

   a_count: assert property (@(posedge clock) disable iff (reset)
      param_count_ff <= lwwc_pkg::PARAM_FULL)
      else $error("parameter count out of range");

   a_cmd_taken: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_chan.payload.action == lwwc_pkg::ACT_COMMAND) |=>
         (current_command_ff == $past(req_chan.payload.value[7:0]) &&
          param_count_ff == 3'd0 && accepting_ff))
      else $error("command not latched");

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LCD window write controller. A queue of bus
// words (window set sequences, pixel bursts and noise) feeds a clocked
// driver; a clocked monitor checks each pixel word against a running
// prediction of the window pointer and the RGB565 to ARGB8888 expansion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam logic [1:0] ACT_UNUSED    = 2'd3;
   localparam int unsigned RANDOM_WORDS = 1250;
   localparam int unsigned IDLE_LIMIT   = 4000;
   localparam int unsigned LONG_HOLD    = 240;
   localparam int unsigned TAIL_CYCLES  = 8;

   typedef struct {
      lwwc_pkg::req_word_type word;
      int unsigned            gap;
      bit                     drain;
   } bus_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lwwc_req_if req_bus ();
   lwwc_rsp_if rsp_bus ();

   lcd_window_write_controller uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   bus_item_type           pending_words[$];
   lwwc_pkg::rsp_word_type pixel_expect_q[$];
   int unsigned            fail_count = 0;
   int unsigned            counted_words = 0;
   bit                     tx_quiet = 1'b0;

   // predicted controller state
   logic [7:0]  cmd_now;
   logic [7:0]  prm [0:2];
   logic [2:0]  prm_cnt;
   logic        taking;
   logic [15:0] col_lo, col_hi, row_lo, row_hi, col_ptr, row_ptr;

   initial begin
      cmd_now = '0;
      prm[0] = '0; prm[1] = '0; prm[2] = '0;
      prm_cnt = '0;
      taking = 1'b1;
      col_lo = '0; col_hi = '0; row_lo = '0; row_hi = '0;
      col_ptr = '0; row_ptr = '0;
   end

   // one parameter byte for a column or page range; fourth byte commits
   function automatic void take_range_byte(input logic [7:0] b, inout logic [15:0] lo,
                                           inout logic [15:0] hi);
      if (taking) begin
         if (prm_cnt < 3'd3) begin
            prm[prm_cnt[1:0]] = b;
            prm_cnt = prm_cnt + 3'd1;
         end else begin
            lo = {prm[0], prm[1]};
            hi = {prm[2], b};
            prm_cnt = 3'd4;
            taking = 1'b0;
         end
      end
   endfunction

   function automatic lwwc_pkg::rsp_word_type predict_pixel_word(
      input lwwc_pkg::req_word_type w);
      lwwc_pkg::rsp_word_type r;
      logic [7:0]   low;
      logic         in_write;
      logic [31:0]  v;
      r = '0;
      low = w.value[7:0];
      v = {16'd0, w.value};
      in_write = (cmd_now == lwwc_pkg::OP_WRITE_START) ||
                 (cmd_now == lwwc_pkg::OP_WRITE_CONTINUE);
      if (w.action == lwwc_pkg::ACT_COMMAND) begin
         taking = 1'b1;
         prm_cnt = '0;
         cmd_now = low;
         if (low == lwwc_pkg::OP_WRITE_START) begin
            col_ptr = col_lo;
            row_ptr = row_lo;
         end
      end else if (w.action == lwwc_pkg::ACT_BYTE || w.action == lwwc_pkg::ACT_WORD) begin
         if (w.action == lwwc_pkg::ACT_WORD && in_write) begin
            if (taking) begin
               r.pixel_valid = 1'b1;
               r.pixel_x = col_ptr;
               r.pixel_y = row_ptr;
               r.pixel_color = 32'hFF00_0000 | (((v & 32'hF800) >> 8) << 16)
                             | (((v & 32'h07E0) >> 3) << 8) | ((v & 32'h001F) << 3);
               col_ptr = col_ptr + 16'd1;
               if (col_ptr > col_hi) begin
                  col_ptr = col_lo;
                  row_ptr = row_ptr + 16'd1;
                  if (row_ptr > row_hi) taking = 1'b0;
               end
            end
         end else if (!in_write && cmd_now == lwwc_pkg::OP_SET_COLUMN) begin
            take_range_byte(low, col_lo, col_hi);
         end else if (!in_write && cmd_now == lwwc_pkg::OP_SET_PAGE) begin
            take_range_byte(low, row_lo, row_hi);
         end else begin
            r.data_ignored = 1'b1;
         end
      end
      return r;
   endfunction

   // ---------------- stimulus helpers ----------------
   task automatic push_bus_word(input logic [1:0] act, input logic [15:0] val,
                                input bit drain = 1'b0);
      bus_item_type it;
      it.word.action = act;
      it.word.value = val;
      it.gap = tx_quiet ? 0 : $urandom_range(0, 3);
      it.drain = drain;
      pending_words.push_back(it);
      if (act != ACT_UNUSED) counted_words++;
   endtask

   task automatic push_param_byte(input logic [7:0] b);
      if ($urandom_range(0, 1) == 0)
         push_bus_word(lwwc_pkg::ACT_BYTE, {8'h00, b});
      else
         push_bus_word(lwwc_pkg::ACT_WORD, {8'($urandom_range(0, 255)), b});
   endtask

   task automatic push_range_set(input logic [7:0] op, input int unsigned max_span);
      logic [15:0] lo, hi;
      int unsigned n;
      case ($urandom_range(0, 6))
         0: lo = 16'hFFFF - 16'($urandom_range(0, 6));
         1: lo = 16'($urandom);
         default: lo = 16'($urandom_range(0, 300));
      endcase
      if ($urandom_range(0, 4) == 0) hi = 16'($urandom);
      else hi = lo + 16'($urandom_range(0, max_span));
      n = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 6) : 4;
      push_bus_word(lwwc_pkg::ACT_COMMAND, {8'($urandom_range(0, 255)), op},
                    $urandom_range(0, 60) == 0);
      if (n > 0) push_param_byte(lo[15:8]);
      if (n > 1) push_param_byte(lo[7:0]);
      if (n > 2) push_param_byte(hi[15:8]);
      if (n > 3) push_param_byte(hi[7:0]);
      for (int i = 4; i < n; i++) push_param_byte(8'($urandom));
   endtask

   task automatic push_pixel_burst();
      int unsigned n;
      logic [15:0] colour;
      n = $urandom_range(0, 40);
      push_bus_word(lwwc_pkg::ACT_COMMAND,
                    {8'($urandom), ($urandom_range(0, 3) == 0) ? lwwc_pkg::OP_WRITE_CONTINUE
                                                                : lwwc_pkg::OP_WRITE_START});
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 19))
            0: colour = 16'h0000;
            1: colour = 16'hFFFF;
            default: colour = 16'($urandom);
         endcase
         if ($urandom_range(0, 24) == 0) push_bus_word(lwwc_pkg::ACT_BYTE, colour);
         else push_bus_word(lwwc_pkg::ACT_WORD, colour);
      end
   endtask

   // ---------------- stimulus and end of run ----------------
   initial begin
      req_bus.valid = 1'b0;
      req_bus.payload = '0;
      rsp_bus.ready = 1'b0;

      // directed: data with no command, unused action, small window, drop at end
      push_bus_word(lwwc_pkg::ACT_BYTE, 16'h0000);
      push_bus_word(lwwc_pkg::ACT_WORD, 16'hFFFF);
      push_bus_word(ACT_UNUSED, 16'hFFFF);
      push_bus_word(lwwc_pkg::ACT_COMMAND, {8'hFF, lwwc_pkg::OP_SET_COLUMN});
      push_bus_word(lwwc_pkg::ACT_BYTE, 16'h0000);
      push_bus_word(lwwc_pkg::ACT_WORD, 16'hAB01);
      push_bus_word(lwwc_pkg::ACT_BYTE, 16'h0000);
      push_bus_word(lwwc_pkg::ACT_BYTE, 16'h0002);
      push_bus_word(lwwc_pkg::ACT_BYTE, 16'h00FF);
      push_bus_word(lwwc_pkg::ACT_COMMAND, {8'h00, lwwc_pkg::OP_SET_PAGE});
      push_bus_word(lwwc_pkg::ACT_BYTE, 16'h0000);
      push_bus_word(lwwc_pkg::ACT_BYTE, 16'h0000);
      push_bus_word(lwwc_pkg::ACT_BYTE, 16'h0000);
      push_bus_word(lwwc_pkg::ACT_BYTE, 16'h0000);
      push_bus_word(lwwc_pkg::ACT_COMMAND, {8'h00, lwwc_pkg::OP_WRITE_START});
      push_bus_word(lwwc_pkg::ACT_WORD, 16'hFFFF);
      push_bus_word(lwwc_pkg::ACT_WORD, 16'hF800);
      push_bus_word(lwwc_pkg::ACT_WORD, 16'h07E0);
      push_bus_word(lwwc_pkg::ACT_BYTE, 16'h001F);
      push_bus_word(lwwc_pkg::ACT_COMMAND, {8'h00, lwwc_pkg::OP_WRITE_CONTINUE});
      push_bus_word(lwwc_pkg::ACT_WORD, 16'h001F);
      push_bus_word(lwwc_pkg::ACT_WORD, 16'h0000);
      push_bus_word(lwwc_pkg::ACT_COMMAND, 16'hFFFF);
      push_bus_word(lwwc_pkg::ACT_WORD, 16'h1234);

      counted_words = 0;
      push_bus_word(lwwc_pkg::ACT_COMMAND, {8'h00, lwwc_pkg::OP_WRITE_CONTINUE}, 1'b1);
      while (counted_words < RANDOM_WORDS) begin
         tx_quiet = ($urandom_range(0, 5) == 0);
         case ($urandom_range(0, 9))
            0, 1:    push_range_set(lwwc_pkg::OP_SET_COLUMN, 7);
            2, 3:    push_range_set(lwwc_pkg::OP_SET_PAGE, 3);
            4, 5, 6, 7: push_pixel_burst();
            default: begin
               for (int i = $urandom_range(1, 4); i > 0; i--)
                  push_bus_word(2'($urandom_range(0, 3)), 16'($urandom));
            end
         endcase
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_bus.valid || pixel_expect_q.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (pixel_expect_q.size() != 0) begin
         $error("%0d expected pixel words never arrived", pixel_expect_q.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // ---------------- driver ----------------
   int unsigned  gap_left;
   bit           drv_fire;
   bus_item_type drv_next;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.payload <= '0;
         gap_left <= 0;
      end else begin
         drv_fire = req_bus.valid && req_bus.ready;
         if (drv_fire) pixel_expect_q.push_back(predict_pixel_word(req_bus.payload));
         if (!req_bus.valid || drv_fire) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               req_bus.valid <= 1'b0;
            end else if (pending_words.size() != 0 &&
                         !(pending_words[0].drain && pixel_expect_q.size() != 0)) begin
               drv_next = pending_words.pop_front();
               req_bus.payload <= drv_next.word;
               req_bus.valid <= 1'b1;
               gap_left <= (pending_words.size() != 0) ? pending_words[0].gap : 0;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- monitor ----------------
   int unsigned            hold_left;
   int unsigned            hold_now;
   int unsigned            rsp_seen = 0;
   lwwc_pkg::rsp_word_type want;

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] got_v);
      if (exp_v !== got_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, got_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= 0;
      end else begin
         hold_now = hold_left;
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pixel_expect_q.size() == 0) begin
               $error("pixel word with nothing expected");
               fail_count++;
            end else begin
               want = pixel_expect_q.pop_front();
               check_field("pixel_valid", 32'(want.pixel_valid),
                           32'(rsp_bus.payload.pixel_valid));
               check_field("pixel_x", 32'(want.pixel_x), 32'(rsp_bus.payload.pixel_x));
               check_field("pixel_y", 32'(want.pixel_y), 32'(rsp_bus.payload.pixel_y));
               check_field("pixel_color", want.pixel_color, rsp_bus.payload.pixel_color);
               check_field("data_ignored", 32'(want.data_ignored),
                           32'(rsp_bus.payload.data_ignored));
            end
            rsp_seen++;
            // long back-pressure so the output register fills and req ready drops
            if (rsp_seen == 400 || rsp_seen == 900) hold_now = LONG_HOLD;
            else if ((rsp_seen / 150) % 4 == 2) hold_now = 0;
            else hold_now = $urandom_range(0, 3);
         end
         if (hold_now != 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left <= hold_now - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
            hold_left <= 0;
         end
      end
   end

   // ---------------- watchdog ----------------
   int unsigned idle_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

endmodule

// ===== files.f =====
src/lwwc_pkg.sv
src/lwwc_if.sv
src/lcd_window_write_controller.sv
tb/sv/tb_top.sv
